FILE: hw/rtl/fsa_pkg.sv
// Shared constants and types for the fixed-slot free-list allocator.
package fsa_pkg;

    localparam int NUM_SLOTS = 1024;
    localparam int SLOT_W    = 10;
    localparam int COUNT_W   = 11;
    localparam int STATUS_W  = 3;
    localparam int ADDR_W    = $clog2(NUM_SLOTS);
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam logic OP_ACQUIRE = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_REUSED    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FRESH     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_RELEASED  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BADREL    = 3'd4;

    // register word index within the APB window
    localparam logic REG_EXPECTED_LEAKS = 1'b0;

    typedef struct packed {
        logic take;        // request accepted this cycle
        logic pop_finish;  // link data for a pending pop is on the RAM output
    } fsa_cmd_t;

    typedef struct packed {
        logic pop_needed;  // presented request is an acquire with a non-empty list
        logic out_blocked; // result register full and not being drained
    } fsa_stat_t;

endpackage

FILE: hw/rtl/fsa_ram.sv
// Generic simple dual-port RAM with registered read.
module fsa_ram
    #(
        parameter int WIDTH = 10,
        parameter int DEPTH = 1024
    )
    (
        input  logic                     clk,
        input  logic                     we,
        input  logic [$clog2(DEPTH)-1:0] waddr,
        input  logic [WIDTH-1:0]         wdata,
        input  logic [$clog2(DEPTH)-1:0] raddr,
        output logic [WIDTH-1:0]         rdata
    );

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hw/rtl/fsa_ctrl.sv
// Control state machine: request handshake and pop sequencing.
module fsa_ctrl
    import fsa_pkg::*;
    (
        input  logic      clk,
        input  logic      rst_n,
        input  logic      in_valid,
        output logic      in_ready,
        input  fsa_stat_t stat,
        output fsa_cmd_t  cmd
    );

    localparam logic S_IDLE = 1'b0;
    localparam logic S_POP  = 1'b1;

    logic state_reg;
    logic state_next;

    always_comb
    begin
        in_ready       = (state_reg == S_IDLE) && !stat.out_blocked;
        cmd.take       = in_valid && in_ready;
        cmd.pop_finish = (state_reg == S_POP);
        state_next     = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.take && stat.pop_needed)
                begin
                    state_next = S_POP;
                end
            end
            S_POP:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: hw/rtl/fsa_dp.sv
// Datapath: free-list head, counters, link RAM, config register and result register.
module fsa_dp
    import fsa_pkg::*;
    (
        input  logic                clk,
        input  logic                rst_n,
        input  fsa_cmd_t            cmd,
        output fsa_stat_t           stat,
        input  logic                opcode,
        input  logic [SLOT_W-1:0]   slot_index,
        output logic                out_valid,
        input  logic                out_ready,
        output logic [SLOT_W-1:0]   granted_slot,
        output logic [STATUS_W-1:0] status,
        output logic [COUNT_W-1:0]  leaked_count,
        output logic                leak_match,
        input  logic                psel,
        input  logic                penable,
        input  logic                pwrite,
        input  logic [PADDR_W-1:0]  paddr,
        input  logic [PDATA_W-1:0]  pwdata,
        output logic [PDATA_W-1:0]  prdata
    );

    logic [SLOT_W-1:0]   free_head_reg,   free_head_next;
    logic [COUNT_W-1:0]  free_length_reg, free_length_next;
    logic [COUNT_W-1:0]  bump_count_reg,  bump_count_next;
    logic [COUNT_W-1:0]  expected_reg;
    logic                out_valid_reg,   out_valid_next;
    logic [SLOT_W-1:0]   granted_reg,     granted_next;
    logic [STATUS_W-1:0] status_reg,      status_next;
    logic [COUNT_W-1:0]  leaked_reg,      leaked_next;
    logic                match_reg,       match_next;

    logic              ram_we;
    logic [SLOT_W-1:0] link_rdata;
    logic              list_empty;
    logic              rel_ok;
    logic              load_out;

    fsa_ram
        #(
            .WIDTH (SLOT_W),
            .DEPTH (NUM_SLOTS)
        )
        u_link_ram
        (
            .clk   (clk),
            .we    (ram_we),
            .waddr (slot_index[ADDR_W-1:0]),
            .wdata (free_head_reg),
            .raddr (free_head_reg[ADDR_W-1:0]),
            .rdata (link_rdata)
        );

    assign list_empty = (free_length_reg == '0);
    assign rel_ok     = ({1'b0, slot_index} < bump_count_reg)
                        && (free_length_reg < bump_count_reg);

    assign stat.pop_needed  = (opcode == OP_ACQUIRE) && !list_empty;
    assign stat.out_blocked = out_valid_reg && !out_ready;

    assign ram_we = cmd.take && (opcode == OP_RELEASE) && rel_ok;

    always_comb
    begin
        free_head_next   = free_head_reg;
        free_length_next = free_length_reg;
        bump_count_next  = bump_count_reg;
        granted_next     = granted_reg;
        status_next      = status_reg;
        load_out         = 1'b0;

        if (cmd.pop_finish)
        begin
            // pop completes once the link of the old head is out of the RAM
            granted_next     = free_head_reg;
            free_head_next   = link_rdata;
            free_length_next = free_length_reg - COUNT_W'(1);
            status_next      = ST_REUSED;
            load_out         = 1'b1;
        end
        else if (cmd.take && !stat.pop_needed)
        begin
            load_out     = 1'b1;
            granted_next = '0;
            if (opcode == OP_ACQUIRE)
            begin
                if (bump_count_reg < COUNT_W'(NUM_SLOTS))
                begin
                    granted_next    = bump_count_reg[SLOT_W-1:0];
                    bump_count_next = bump_count_reg + COUNT_W'(1);
                    status_next     = ST_FRESH;
                end
                else
                begin
                    status_next = ST_EXHAUSTED;
                end
            end
            else if (rel_ok)
            begin
                free_head_next   = slot_index;
                free_length_next = free_length_reg + COUNT_W'(1);
                status_next      = ST_RELEASED;
            end
            else
            begin
                status_next = ST_BADREL;
            end
        end

        leaked_next = bump_count_next - free_length_next;
        match_next  = (leaked_next == expected_reg);

        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_head_reg   <= '0;
            free_length_reg <= '0;
            bump_count_reg  <= '0;
            expected_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            free_head_reg   <= free_head_next;
            free_length_reg <= free_length_next;
            bump_count_reg  <= bump_count_next;
            out_valid_reg   <= out_valid_next;
            if (psel && penable && pwrite && (paddr[2] == REG_EXPECTED_LEAKS))
            begin
                expected_reg <= pwdata[COUNT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            granted_reg <= granted_next;
            status_reg  <= status_next;
            leaked_reg  <= leaked_next;
            match_reg   <= match_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_EXPECTED_LEAKS)
        begin
            prdata = {{(PDATA_W-COUNT_W){1'b0}}, expected_reg};
        end
    end

    assign out_valid    = out_valid_reg;
    assign granted_slot = granted_reg;
    assign status       = status_reg;
    assign leaked_count = leaked_reg;
    assign leak_match   = match_reg;

endmodule

FILE: hw/rtl/fixed_slot_free_list_allocator_top.sv
// Fixed-slot allocator: LIFO free list over a link RAM plus a bump counter.
// Fresh, release and failure results are registered in the cycle after the request;
// a reused slot also passes the pop state, which waits on the link RAM's registered read.
// Throughput: one request per cycle, but none while a reused slot's pop is in progress.
// A result waiting in the output register holds off the next request until it is taken.
// Reset (rst_n, async low) empties the free list, clears counters and expected_leaks;
// the link RAM is not cleared, as only links written by earlier releases are ever read.
module fixed_slot_free_list_allocator_top
    import fsa_pkg::*;
    (
        input  logic                clk,
        input  logic                rst_n,
        input  logic                in_valid,
        output logic                in_ready,
        input  logic                opcode,
        input  logic [SLOT_W-1:0]   slot_index,
        output logic                out_valid,
        input  logic                out_ready,
        output logic [SLOT_W-1:0]   granted_slot,
        output logic [STATUS_W-1:0] status,
        output logic [COUNT_W-1:0]  leaked_count,
        output logic                leak_match,
        input  logic                psel,
        input  logic                penable,
        input  logic                pwrite,
        input  logic [PADDR_W-1:0]  paddr,
        input  logic [PDATA_W-1:0]  pwdata,
        output logic [PDATA_W-1:0]  prdata,
        output logic                pready
    );

    fsa_cmd_t  cmd;
    fsa_stat_t stat;

    assign pready = 1'b1;

    fsa_ctrl u_ctrl
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_valid (in_valid),
            .in_ready (in_ready),
            .stat     (stat),
            .cmd      (cmd)
        );

    fsa_dp u_dp
        (
            .clk          (clk),
            .rst_n        (rst_n),
            .cmd          (cmd),
            .stat         (stat),
            .opcode       (opcode),
            .slot_index   (slot_index),
            .out_valid    (out_valid),
            .out_ready    (out_ready),
            .granted_slot (granted_slot),
            .status       (status),
            .leaked_count (leaked_count),
            .leak_match   (leak_match),
            .psel         (psel),
            .penable      (penable),
            .pwrite       (pwrite),
            .paddr        (paddr),
            .pwdata       (pwdata),
            .prdata       (prdata)
        );

endmodule
